// ===== hw/rtl/oal_pkg.sv =====
// shared constants, codes and types of the ordered array list
package oal_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);

  localparam int FUNC_W = 2;
  localparam int POS_W  = 10;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 9;

  // width wide enough to compare a position against the count
  localparam int CMP_W = (COUNT_W > POS_W) ? COUNT_W : POS_W;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_APPEND = 2'd0;
  localparam logic [FUNC_W-1:0] FN_GET    = 2'd1;
  localparam logic [FUNC_W-1:0] FN_SET    = 2'd2;
  localparam logic [FUNC_W-1:0] FN_DELETE = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_INDEX = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // write port of the element store
  typedef struct packed {
    logic                     we;
    logic [ADDR_W-1:0]        addr;
    logic signed [DATA_W-1:0] data;
  } store_wr_t;

endpackage

// ===== hw/rtl/oal_req_if.sv =====
// request channel: operation, position and value
interface oal_req_if;
  logic                             valid;
  logic                             ready;
  logic [oal_pkg::FUNC_W-1:0]       func;
  logic [oal_pkg::POS_W-1:0]        position;
  logic signed [oal_pkg::DATA_W-1:0] value_in;

  modport source (output valid, output func, output position, output value_in, input ready);
  modport sink (input valid, input func, input position, input value_in, output ready);
endinterface

// ===== hw/rtl/oal_rsp_if.sv =====
// response channel: status, value read and element count
interface oal_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [oal_pkg::STAT_W-1:0]       status;
  logic signed [oal_pkg::DATA_W-1:0] value_out;
  logic [oal_pkg::LEN_W-1:0]        length;

  modport source (output valid, output status, output value_out, output length, input ready);
  modport sink (input valid, input status, input value_out, input length, output ready);
endinterface

// ===== hw/rtl/oal_store.sv =====
// element store: one write port, one registered read port
module oal_store (
  input  logic                              clk,
  input  oal_pkg::store_wr_t                wr,
  input  logic [oal_pkg::ADDR_W-1:0]        raddr,
  output logic signed [oal_pkg::DATA_W-1:0] rdata
);

  logic signed [oal_pkg::DATA_W-1:0] mem [oal_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/ordered_array_list_top.sv =====
// top level of the ordered array list: sequencer, count and response register
//
// the block keeps a packed list of signed 32-bit words in a store of
// CAPACITY entries. each request beat carries one operation (append, get,
// set, delete) with a position and a value; each request gives exactly one
// response beat with a status, the value read by a get and the count after
// the operation.
// append, set and every error answer in the cycle after the request beat;
// get passes through the S_GET state first, since the store has a registered
// read. delete of entry p from a list of n entries moves the later entries
// down one per cycle through the single store port pair and then answers;
// removing the last entry moves nothing and answers like an append.
// the request side takes the next beat as soon as the sequencer is back to
// idle and the response register is empty or being emptied in that cycle.
// reset clears the count and the sequencer; the store keeps its contents,
// as no entry is read before it has been written, so no clearing pass runs.
// a stalled response holds the response register and the request side
// waits; nothing is dropped.
module ordered_array_list_top (
  input logic         clk,
  input logic         rst,
  oal_req_if.sink     request,
  oal_rsp_if.source   response
);

  // sequencer codes
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_GET   = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;

  logic [1:0]                         state, state_next;
  logic [oal_pkg::COUNT_W-1:0]        count, count_next;
  logic [oal_pkg::ADDR_W-1:0]         ptr, ptr_next;

  // response register
  logic                               rsp_valid;
  logic [oal_pkg::STAT_W-1:0]         rsp_status;
  logic signed [oal_pkg::DATA_W-1:0]  rsp_value;
  logic [oal_pkg::LEN_W-1:0]          rsp_length;

  logic                               load;
  logic [oal_pkg::STAT_W-1:0]         ld_status;
  logic signed [oal_pkg::DATA_W-1:0]  ld_value;

  oal_pkg::store_wr_t                 wr;
  logic [oal_pkg::ADDR_W-1:0]         rd_addr;
  logic signed [oal_pkg::DATA_W-1:0]  rd_data;

  logic                               accept;
  logic                               in_range;
  logic                               full;
  logic [oal_pkg::ADDR_W-1:0]         pos_addr;

  // take a request only when idle and the response slot is free this cycle
  assign request.ready = (state == S_IDLE) && (!rsp_valid || response.ready);
  assign accept        = request.valid && request.ready;

  // full-width compare so that any position at or past the count is out of range
  assign in_range = oal_pkg::CMP_W'(request.position) < oal_pkg::CMP_W'(count);
  assign full     = (count == oal_pkg::COUNT_W'(oal_pkg::CAPACITY));
  assign pos_addr = oal_pkg::ADDR_W'(request.position);

  oal_store u_store (
    .clk   (clk),
    .wr    (wr),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    state_next = state;
    count_next = count;
    ptr_next   = ptr;
    wr         = '0;
    rd_addr    = pos_addr;
    load       = 1'b0;
    ld_status  = oal_pkg::STAT_OK;
    ld_value   = '0;

    unique case (state)
      S_IDLE: begin
        // delete primes the shift with the entry just above the hole
        if (request.func == oal_pkg::FN_DELETE) begin
          rd_addr = pos_addr + oal_pkg::ADDR_W'(1);
        end
        if (accept) begin
          unique case (request.func)
            oal_pkg::FN_APPEND: begin
              load = 1'b1;
              if (full) begin
                ld_status = oal_pkg::STAT_FULL;
              end else begin
                wr.we      = 1'b1;
                wr.addr    = oal_pkg::ADDR_W'(count);
                wr.data    = request.value_in;
                count_next = count + oal_pkg::COUNT_W'(1);
              end
            end
            oal_pkg::FN_GET: begin
              if (in_range) begin
                state_next = S_GET;
              end else begin
                load      = 1'b1;
                ld_status = oal_pkg::STAT_INDEX;
              end
            end
            oal_pkg::FN_SET: begin
              load = 1'b1;
              if (in_range) begin
                wr.we   = 1'b1;
                wr.addr = pos_addr;
                wr.data = request.value_in;
              end else begin
                ld_status = oal_pkg::STAT_INDEX;
              end
            end
            oal_pkg::FN_DELETE: begin
              if (!in_range) begin
                load      = 1'b1;
                ld_status = oal_pkg::STAT_INDEX;
              end else if (oal_pkg::COUNT_W'(pos_addr) + oal_pkg::COUNT_W'(1) == count) begin
                // last entry: nothing to move
                load       = 1'b1;
                count_next = count - oal_pkg::COUNT_W'(1);
              end else begin
                ptr_next   = pos_addr;
                state_next = S_SHIFT;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_GET: begin
        load       = 1'b1;
        ld_value   = rd_data;
        state_next = S_IDLE;
      end
      S_SHIFT: begin
        // write the entry read last cycle one place down, read the next one
        rd_addr  = ptr + oal_pkg::ADDR_W'(2);
        wr.we    = 1'b1;
        wr.addr  = ptr;
        wr.data  = rd_data;
        ptr_next = ptr + oal_pkg::ADDR_W'(1);
        if (oal_pkg::COUNT_W'(ptr) + oal_pkg::COUNT_W'(2) == count) begin
          load       = 1'b1;
          count_next = count - oal_pkg::COUNT_W'(1);
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (response.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    if (load) begin
      rsp_status <= ld_status;
      rsp_value  <= ld_value;
      rsp_length <= oal_pkg::LEN_W'(count_next);
    end
  end

  assign response.valid     = rsp_valid;
  assign response.status    = rsp_status;
  assign response.value_out = rsp_value;
  assign response.length    = rsp_length;

endmodule

// ===== hw/rtl/oal_checker.sv =====
// port-level checks of the ordered array list and their binding
module oal_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              req_ready,
  input logic                              rsp_valid,
  input logic                              rsp_ready,
  input logic [oal_pkg::STAT_W-1:0]        rsp_status,
  input logic signed [oal_pkg::DATA_W-1:0] rsp_value,
  input logic [oal_pkg::LEN_W-1:0]         rsp_length
);

  // a stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_value) && $stable(rsp_length))
    else $error("response changed while stalled");

  // a request is only taken when the response slot frees up
  a_req_slot: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !rsp_valid || rsp_ready)
    else $error("request ready while response blocked");

  // errors never carry a value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != oal_pkg::STAT_OK |-> rsp_value == '0)
    else $error("error response with nonzero value");

  // full is reported only at capacity
  a_full_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == oal_pkg::STAT_FULL
      |-> rsp_length == oal_pkg::LEN_W'(oal_pkg::CAPACITY))
    else $error("full status below capacity");

endmodule

bind ordered_array_list_top oal_checker u_oal_checker (
  .clk        (clk),
  .rst        (rst),
  .req_ready  (request.ready),
  .rsp_valid  (response.valid),
  .rsp_ready  (response.ready),
  .rsp_status (response.status),
  .rsp_value  (response.value_out),
  .rsp_length (response.length)
);
